// File: src/assert_macros.svh
// Assertion macros shared by the timer queue RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DTQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/dtq_pkg.sv
// Shared types and constants for the deadline timer queue.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dtq_pkg;

   localparam int NOW_W    = 48;
   localparam int TMO_W    = 32;
   localparam int TAG_W    = 32;
   localparam int DL_W     = 49;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 3;
   localparam int REM_W    = 32;

   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_DELETE  = 2'd1,
      OP_PROCESS = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED      = 3'd0,
      ST_FULL       = 3'd1,
      ST_REMOVED    = 3'd2,
      ST_NOT_ACTIVE = 3'd3,
      ST_FIRED      = 3'd4,
      ST_WAITING    = 3'd5,
      ST_EMPTY      = 3'd6,
      ST_CLEARED    = 3'd7
   } status_type;

   // engine -> allocator
   typedef struct packed {
      logic scan_start;
      logic set_en;     // mark the last found slot active
      logic clr_en;     // free clr_idx
      logic clr_all;
   } alloc_cmd_type;

   // allocator -> engine
   typedef struct packed {
      logic scan_done;
      logic scan_found;
   } alloc_stat_type;

endpackage

// File: src/dtq_alloc.sv
// Slot allocator: active flags per slot and lowest-free-slot scan.
// Depends on dtq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtq_alloc #(
   parameter int NUM_TIMERS = 16,
   localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dtq_pkg::alloc_cmd_type  cmd,
   input  logic [SW-1:0]           clr_idx,
   input  logic [SW-1:0]           query_idx,
   output logic                    query_active,
   output dtq_pkg::alloc_stat_type stat,
   output logic [SW-1:0]           found_idx
);

   localparam int GRP  = 8;
   localparam int PW   = $clog2(GRP);
   localparam int NGRP = (NUM_TIMERS + GRP - 1) / GRP;
   localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int PADN = NGRP * GRP;

   logic [NUM_TIMERS-1:0]   active_ff;
   logic [PADN-1:0]         free_vec;
   logic [GRP-1:0]          grp_bits;
   logic [PW-1:0]           pos;
   logic                    any_free;
   logic                    busy_ff;
   logic [GW-1:0]           grp_ff;
   dtq_pkg::alloc_stat_type stat_ff;
   logic [SW-1:0]           found_idx_ff;

   for (genvar g = 0; g < PADN; g++) begin : g_free
      if (g < NUM_TIMERS) begin : g_real
         assign free_vec[g] = ~active_ff[g];
      end else begin : g_pad
         assign free_vec[g] = 1'b0;
      end
   end

   // one group of eight per cycle
   always_comb begin
      grp_bits = free_vec[32'(grp_ff) * GRP +: GRP];
      any_free = |grp_bits;
      pos      = '0;
      for (int j = GRP - 1; j >= 0; j--) begin
         if (grp_bits[j]) begin
            pos = PW'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         busy_ff   <= 1'b0;
         stat_ff   <= '0;
      end else begin
         stat_ff <= '0;
         if (cmd.clr_all) begin
            active_ff <= '0;
         end else begin
            if (cmd.set_en) begin
               active_ff[found_idx_ff] <= 1'b1;
            end
            if (cmd.clr_en) begin
               active_ff[clr_idx] <= 1'b0;
            end
         end
         if (cmd.scan_start) begin
            busy_ff <= 1'b1;
            grp_ff  <= '0;
         end else if (busy_ff) begin
            if (any_free) begin
               busy_ff            <= 1'b0;
               stat_ff.scan_done  <= 1'b1;
               stat_ff.scan_found <= 1'b1;
               found_idx_ff       <= SW'({grp_ff, pos});
            end else if (grp_ff == GW'(NGRP - 1)) begin
               busy_ff           <= 1'b0;
               stat_ff.scan_done <= 1'b1;
            end else begin
               grp_ff <= grp_ff + 1'b1;
            end
         end
      end
   end

   assign query_active = active_ff[query_idx];
   assign stat         = stat_ff;
   assign found_idx    = found_idx_ff;

   `DTQ_ASSERT(a_found_is_free, clock, reset,
      stat_ff.scan_done && stat_ff.scan_found |-> !active_ff[found_idx_ff],
      "allocator returned a slot that is already active")
   `DTQ_ASSERT(a_done_after_busy, clock, reset,
      stat_ff.scan_done |-> $past(busy_ff),
      "scan done without a scan in progress")

endmodule

// File: src/dtq_engine.sv
// List engine: sorted deadline list held in node and tag memories, walked
// one entry per cycle. Depends on dtq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtq_engine #(
   parameter int NUM_TIMERS = 16,
   localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [1:0]                      in_op,
   input  logic [dtq_pkg::NOW_W-1:0]       in_now_us,
   input  logic [dtq_pkg::TMO_W-1:0]       in_timeout_us,
   input  logic [dtq_pkg::TAG_W-1:0]       in_tag,
   input  logic [dtq_pkg::SLOT_W-1:0]      in_slot,
   output logic                            res_valid,
   input  logic                            res_take,
   output logic [dtq_pkg::STATUS_W-1:0]    res_status,
   output logic [dtq_pkg::SLOT_W-1:0]      res_slot_out,
   output logic [dtq_pkg::TAG_W-1:0]       res_tag_out,
   output logic [dtq_pkg::REM_W-1:0]       res_remaining_us,
   output dtq_pkg::alloc_cmd_type          alloc_cmd,
   output logic [SW-1:0]                   clr_idx,
   output logic [SW-1:0]                   query_idx,
   input  logic                            query_active,
   input  dtq_pkg::alloc_stat_type         alloc_stat,
   input  logic [SW-1:0]                   found_idx
);

   localparam int LW = $clog2(NUM_TIMERS + 1);
   localparam logic [LW-1:0] LINK_NONE = LW'(NUM_TIMERS);

   typedef struct packed {
      logic [dtq_pkg::DL_W-1:0] dl;
      logic [LW-1:0]            nxt;
   } node_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_WALK,
      S_LINK_NEW,
      S_LINK_PREV,
      S_DEL_CHK,
      S_DEL_WALK,
      S_PROC,
      S_DONE
   } state_type;

   state_type                     state_ff;
   logic [dtq_pkg::NOW_W-1:0]     now_ff;
   logic [dtq_pkg::DL_W-1:0]      dl_ff;
   logic [dtq_pkg::TAG_W-1:0]     tag_ff;
   logic [dtq_pkg::SLOT_W-1:0]    slot_ff;
   logic [SW-1:0]                 new_ff;
   logic [LW-1:0]                 head_ff;
   logic [LW-1:0]                 cur_ff;
   logic [LW-1:0]                 prev_ff;
   logic [dtq_pkg::DL_W-1:0]      prev_dl_ff;
   dtq_pkg::status_type           status_ff;
   logic [dtq_pkg::SLOT_W-1:0]    slot_out_ff;
   logic [dtq_pkg::TAG_W-1:0]     tag_out_ff;
   logic [dtq_pkg::REM_W-1:0]     rem_ff;

   node_type                      node_mem [NUM_TIMERS];
   logic [dtq_pkg::TAG_W-1:0]     tag_mem  [NUM_TIMERS];
   node_type                      node_rd_ff;
   logic [dtq_pkg::TAG_W-1:0]     tag_rd_ff;

   logic                          node_re;
   logic [SW-1:0]                 node_raddr;
   logic                          node_we;
   logic [SW-1:0]                 node_waddr;
   node_type                      node_wdata;
   logic                          tag_re;
   logic                          tag_we;

   logic                          del_hit;
   logic                          del_match;
   logic                          walk_on;
   logic                          fire;
   logic [dtq_pkg::DL_W-1:0]      diff;

   assign del_hit   = (32'(slot_ff) < 32'(NUM_TIMERS)) && query_active;
   assign del_match = (cur_ff == LW'(slot_ff));
   assign walk_on   = (node_rd_ff.dl <= dl_ff);
   assign fire      = (dtq_pkg::DL_W'(now_ff) >= node_rd_ff.dl);
   assign diff      = node_rd_ff.dl - dtq_pkg::DL_W'(now_ff);
   assign query_idx = SW'(slot_ff);

   always_comb begin
      node_re    = 1'b0;
      node_raddr = head_ff[SW-1:0];
      node_we    = 1'b0;
      node_waddr = new_ff;
      node_wdata = '{dl: dl_ff, nxt: cur_ff};
      tag_re     = 1'b0;
      tag_we     = 1'b0;
      alloc_cmd  = '0;
      clr_idx    = head_ff[SW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               unique case (dtq_pkg::op_type'(in_op))
                  dtq_pkg::OP_ADD: alloc_cmd.scan_start = 1'b1;
                  dtq_pkg::OP_PROCESS: begin
                     node_re = (head_ff != LINK_NONE);
                     tag_re  = (head_ff != LINK_NONE);
                  end
                  dtq_pkg::OP_CLEAR: alloc_cmd.clr_all = 1'b1;
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (alloc_stat.scan_done && alloc_stat.scan_found) begin
               alloc_cmd.set_en = 1'b1;
               tag_we           = 1'b1;
               if (head_ff == LINK_NONE) begin
                  node_we    = 1'b1;
                  node_waddr = found_idx;
                  node_wdata = '{dl: dl_ff, nxt: LINK_NONE};
               end else begin
                  node_re = 1'b1;
               end
            end
         end
         S_WALK: begin
            if (walk_on && node_rd_ff.nxt != LINK_NONE) begin
               node_re    = 1'b1;
               node_raddr = node_rd_ff.nxt[SW-1:0];
            end
         end
         S_LINK_NEW: node_we = 1'b1;
         S_LINK_PREV: begin
            node_we    = 1'b1;
            node_waddr = prev_ff[SW-1:0];
            node_wdata = '{dl: prev_dl_ff, nxt: LW'(new_ff)};
         end
         S_DEL_CHK: begin
            if (del_hit) begin
               alloc_cmd.clr_en = 1'b1;
               clr_idx          = SW'(slot_ff);
               node_re          = 1'b1;
            end
         end
         S_DEL_WALK: begin
            if (del_match) begin
               if (prev_ff != LINK_NONE) begin
                  node_we    = 1'b1;
                  node_waddr = prev_ff[SW-1:0];
                  node_wdata = '{dl: prev_dl_ff, nxt: node_rd_ff.nxt};
               end
            end else begin
               node_re    = 1'b1;
               node_raddr = node_rd_ff.nxt[SW-1:0];
            end
         end
         S_PROC: alloc_cmd.clr_en = fire;
         S_DONE: ;
         default: ;
      endcase
   end

   // node and tag memories, registered read
   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      if (node_re) begin
         node_rd_ff <= node_mem[node_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[found_idx] <= tag_ff;
      end
      if (tag_re) begin
         tag_rd_ff <= tag_mem[head_ff[SW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= LINK_NONE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  now_ff      <= in_now_us;
                  dl_ff       <= dtq_pkg::DL_W'(in_now_us) + dtq_pkg::DL_W'(in_timeout_us);
                  tag_ff      <= in_tag;
                  slot_ff     <= in_slot;
                  slot_out_ff <= '0;
                  tag_out_ff  <= '0;
                  rem_ff      <= '0;
                  unique case (dtq_pkg::op_type'(in_op))
                     dtq_pkg::OP_ADD:    state_ff <= S_SCAN;
                     dtq_pkg::OP_DELETE: state_ff <= S_DEL_CHK;
                     dtq_pkg::OP_PROCESS: begin
                        if (head_ff == LINK_NONE) begin
                           status_ff <= dtq_pkg::ST_EMPTY;
                           state_ff  <= S_DONE;
                        end else begin
                           state_ff <= S_PROC;
                        end
                     end
                     dtq_pkg::OP_CLEAR: begin
                        head_ff   <= LINK_NONE;
                        status_ff <= dtq_pkg::ST_CLEARED;
                        state_ff  <= S_DONE;
                     end
                     default: ;
                  endcase
               end
            end
            S_SCAN: begin
               if (alloc_stat.scan_done) begin
                  if (alloc_stat.scan_found) begin
                     new_ff      <= found_idx;
                     status_ff   <= dtq_pkg::ST_ADDED;
                     slot_out_ff <= dtq_pkg::SLOT_W'(found_idx);
                     cur_ff      <= head_ff;
                     prev_ff     <= LINK_NONE;
                     if (head_ff == LINK_NONE) begin
                        head_ff  <= LW'(found_idx);
                        state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_WALK;
                     end
                  end else begin
                     status_ff <= dtq_pkg::ST_FULL;
                     state_ff  <= S_DONE;
                  end
               end
            end
            S_WALK: begin
               // equal deadlines are passed so the new entry lands after them
               if (walk_on) begin
                  prev_ff    <= cur_ff;
                  prev_dl_ff <= node_rd_ff.dl;
                  cur_ff     <= node_rd_ff.nxt;
                  if (node_rd_ff.nxt == LINK_NONE) begin
                     state_ff <= S_LINK_NEW;
                  end
               end else begin
                  state_ff <= S_LINK_NEW;
               end
            end
            S_LINK_NEW: begin
               if (prev_ff == LINK_NONE) begin
                  head_ff  <= LW'(new_ff);
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_LINK_PREV;
               end
            end
            S_LINK_PREV: state_ff <= S_DONE;
            S_DEL_CHK: begin
               slot_out_ff <= slot_ff;
               cur_ff      <= head_ff;
               prev_ff     <= LINK_NONE;
               if (del_hit) begin
                  status_ff <= dtq_pkg::ST_REMOVED;
                  state_ff  <= S_DEL_WALK;
               end else begin
                  status_ff <= dtq_pkg::ST_NOT_ACTIVE;
                  state_ff  <= S_DONE;
               end
            end
            S_DEL_WALK: begin
               if (del_match) begin
                  if (prev_ff == LINK_NONE) begin
                     head_ff <= node_rd_ff.nxt;
                  end
                  state_ff <= S_DONE;
               end else begin
                  prev_ff    <= cur_ff;
                  prev_dl_ff <= node_rd_ff.dl;
                  cur_ff     <= node_rd_ff.nxt;
               end
            end
            S_PROC: begin
               if (fire) begin
                  head_ff     <= node_rd_ff.nxt;
                  status_ff   <= dtq_pkg::ST_FIRED;
                  slot_out_ff <= dtq_pkg::SLOT_W'(head_ff);
                  tag_out_ff  <= tag_rd_ff;
               end else begin
                  status_ff <= dtq_pkg::ST_WAITING;
                  rem_ff    <= (|diff[dtq_pkg::DL_W-1:dtq_pkg::REM_W]) ? '1
                                                                    : diff[dtq_pkg::REM_W-1:0];
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (res_take) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign in_ready         = (state_ff == S_IDLE);
   assign res_valid        = (state_ff == S_DONE);
   assign res_status       = status_ff;
   assign res_slot_out     = slot_out_ff;
   assign res_tag_out      = tag_out_ff;
   assign res_remaining_us = rem_ff;

   `DTQ_ASSERT(a_no_rw_collision, clock, reset,
      node_we && node_re |-> node_waddr != node_raddr,
      "node memory read and write hit the same entry")
   `DTQ_ASSERT(a_walk_has_entry, clock, reset,
      (state_ff == S_WALK) || (state_ff == S_DEL_WALK) |-> cur_ff != LINK_NONE,
      "list walk reached past the tail")

endmodule

// File: src/deadline_timer_queue.sv
// Deadline timer queue top level: allocator, list engine, result register.
// Depends on dtq_pkg, dtq_alloc, dtq_engine and assert_macros.svh.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_ready | op, now_us, timeout_us, tag, slot
//   rsp_    | out       | rsp_valid/rsp_ready | status, slot_out, tag_out, remaining_us
//
// One item at a time. Clear and empty process go straight to the result; process reads
// the head node; delete checks the slot, then walks to it; add scans for a free slot, then
// (unless the list is empty or the pool full) walks and links, writing the previous node too
// mid-list. Walks read one node a cycle; scans take groups of eight, at most ceil(NUM_TIMERS/8).
// Reset is synchronous and empties the list at once (no clearing pass).
// A waiting result does not block the next transaction; a second one stalls req_ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module deadline_timer_queue #(
   parameter int NUM_TIMERS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_op,
   input  logic [dtq_pkg::NOW_W-1:0]       req_now_us,
   input  logic [dtq_pkg::TMO_W-1:0]       req_timeout_us,
   input  logic [dtq_pkg::TAG_W-1:0]       req_tag,
   input  logic [dtq_pkg::SLOT_W-1:0]      req_slot,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [dtq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [dtq_pkg::SLOT_W-1:0]      rsp_slot_out,
   output logic [dtq_pkg::TAG_W-1:0]       rsp_tag_out,
   output logic [dtq_pkg::REM_W-1:0]       rsp_remaining_us
);

   localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   dtq_pkg::alloc_cmd_type          alloc_cmd;
   dtq_pkg::alloc_stat_type         alloc_stat;
   logic [SW-1:0]                   clr_idx;
   logic [SW-1:0]                   query_idx;
   logic                            query_active;
   logic [SW-1:0]                   found_idx;

   logic                            res_valid;
   logic                            res_take;
   logic [dtq_pkg::STATUS_W-1:0]    res_status;
   logic [dtq_pkg::SLOT_W-1:0]      res_slot_out;
   logic [dtq_pkg::TAG_W-1:0]       res_tag_out;
   logic [dtq_pkg::REM_W-1:0]       res_remaining_us;

   logic                            rsp_valid_ff;
   logic [dtq_pkg::STATUS_W-1:0]    rsp_status_ff;
   logic [dtq_pkg::SLOT_W-1:0]      rsp_slot_out_ff;
   logic [dtq_pkg::TAG_W-1:0]       rsp_tag_out_ff;
   logic [dtq_pkg::REM_W-1:0]       rsp_remaining_us_ff;

   dtq_alloc #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_alloc (
      .clock        (clock),
      .reset        (reset),
      .cmd          (alloc_cmd),
      .clr_idx      (clr_idx),
      .query_idx    (query_idx),
      .query_active (query_active),
      .stat         (alloc_stat),
      .found_idx    (found_idx)
   );

   dtq_engine #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_valid),
      .in_ready         (req_ready),
      .in_op            (req_op),
      .in_now_us        (req_now_us),
      .in_timeout_us    (req_timeout_us),
      .in_tag           (req_tag),
      .in_slot          (req_slot),
      .res_valid        (res_valid),
      .res_take         (res_take),
      .res_status       (res_status),
      .res_slot_out     (res_slot_out),
      .res_tag_out      (res_tag_out),
      .res_remaining_us (res_remaining_us),
      .alloc_cmd        (alloc_cmd),
      .clr_idx          (clr_idx),
      .query_idx        (query_idx),
      .query_active     (query_active),
      .alloc_stat       (alloc_stat),
      .found_idx        (found_idx)
   );

   // output register loads when empty or being drained this cycle
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_status_ff       <= res_status;
         rsp_slot_out_ff     <= res_slot_out;
         rsp_tag_out_ff      <= res_tag_out;
         rsp_remaining_us_ff <= res_remaining_us;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_out     = rsp_slot_out_ff;
   assign rsp_tag_out      = rsp_tag_out_ff;
   assign rsp_remaining_us = rsp_remaining_us_ff;

   `DTQ_ASSERT_NEXT(a_one_in_flight, clock, reset,
      req_valid && req_ready, !req_ready,
      "new transaction accepted while one is in flight")

endmodule
